[rtl/core/cwets_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cwets_pkg: shared types and constants of the 24-hour clock
// Holds the register map, the field widths, the seven-segment table and the
// digit split helpers used by the clock core.
// ----------------------------------------------------------------------------
package cwets_pkg;

	// Field widths.
	localparam int unsigned SEC_W  = 6;
	localparam int unsigned MIN_W  = 6;
	localparam int unsigned HOUR_W = 5;
	localparam int unsigned SEG_W  = 8;
	localparam int unsigned TPS_W  = 8;
	localparam int unsigned ENC_W  = 4;

	// Bus widths.
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 64;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	// Register map, word index taken from paddr[2].
	localparam logic REG_TICKS_PER_SECOND = 1'b0;
	localparam logic [TPS_W-1:0] TPS_RESET = 8'd128;

	// Request kinds carried in tuser.
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Display patterns, active low.
	localparam logic [SEG_W-1:0] SEG_COLON_ON = 8'hFC;
	localparam logic [SEG_W-1:0] SEG_DARK     = 8'hFF;
	localparam logic [SEG_W-1:0] SEG_NONE     = 8'h00;

	// Time limits.
	localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
	localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
	localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;

	// One result request.
	typedef struct packed {
		logic [SEG_W-1:0]  seg_colon;
		logic [SEG_W-1:0]  seg_hour_tens;
		logic [SEG_W-1:0]  seg_hour_ones;
		logic [SEG_W-1:0]  seg_minute_tens;
		logic [SEG_W-1:0]  seg_minute_ones;
		logic [HOUR_W-1:0] hours_now;
		logic [MIN_W-1:0]  minutes_now;
		logic [SEC_W-1:0]  seconds_now;
	} result_t;

	// Segment pattern of one decimal digit.
	function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		begin
			case (d)
				4'd0: s = 8'hC0;
				4'd1: s = 8'hF9;
				4'd2: s = 8'hA4;
				4'd3: s = 8'hB0;
				4'd4: s = 8'h99;
				4'd5: s = 8'h92;
				4'd6: s = 8'h82;
				4'd7: s = 8'hF8;
				4'd8: s = 8'h80;
				4'd9: s = 8'h98;
				default: s = SEG_NONE;
			endcase
			return s;
		end
	endfunction

	// Tens digit of a value up to 63.
	function automatic logic [2:0] tens_of(input logic [5:0] v);
		logic [2:0] t;
		begin
			if (v >= 6'd60)      t = 3'd6;
			else if (v >= 6'd50) t = 3'd5;
			else if (v >= 6'd40) t = 3'd4;
			else if (v >= 6'd30) t = 3'd3;
			else if (v >= 6'd20) t = 3'd2;
			else if (v >= 6'd10) t = 3'd1;
			else                 t = 3'd0;
			return t;
		end
	endfunction

	// Ones digit of a value up to 63, given its tens digit.
	function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [2:0] t);
		logic [5:0] tens_val;
		logic [5:0] r;
		begin
			tens_val = 6'({t, 3'b000} + {2'b00, t, 1'b0});
			r = v - tens_val;
			return r[3:0];
		end
	endfunction

endpackage
`default_nettype wire

[rtl/core/clock_with_encoder_time_set.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clock_with_encoder_time_set: 24-hour clock with rotary encoder time setting
// Counts timebase ticks into seconds, minutes and hours, applies encoder
// samples to the hour and minute, and returns the time with its display
// patterns for every request.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle on the slave stream: tuser
// selects a timebase tick (0) or an encoder sample (1), and tdata[3:0]
// carries the encoder lines. Every request yields exactly one result on the
// master stream, in the cycle after it is taken, through a single output
// register; the slave side stays ready while that register is empty or is
// being emptied, so a full cycle rate holds as long as the sink takes results.
// The clock state is updated at the edge that takes the request, so the next
// request sees it at once. The prescaler modulus is written over the APB port
// at byte address 0 (a value of 0 counts 256 ticks per second); write it only
// while no request is outstanding.
module clock_with_encoder_time_set (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Request stream.
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [cwets_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [3:0] encoder_bits
	input  wire logic [0:0]                          s_axis_tuser,  // [0] operation
	// Result stream.
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [5:0] seconds_now, [11:6] minutes_now, [16:12] hours_now,
	// [24:17] seg_minute_ones, [32:25] seg_minute_tens, [40:33] seg_hour_ones,
	// [48:41] seg_hour_tens, [56:49] seg_colon, [63:57] zero
	output logic [cwets_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	// Configuration port.
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [cwets_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [cwets_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [cwets_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                     pready
);

	// Clock state.
	logic [cwets_pkg::TPS_W-1:0]  tps_q;
	logic [7:0]                   prescale_q;
	logic [cwets_pkg::SEC_W-1:0]  sec_q;
	logic [cwets_pkg::MIN_W-1:0]  min_q;
	logic [cwets_pkg::HOUR_W-1:0] hour_q;
	logic                         colon_q;
	logic                         last_ha_q;
	logic                         last_ma_q;
	logic                         last_mb_q;

	// Output register.
	logic                         out_valid_q;
	cwets_pkg::result_t           result_q;

	// Next state.
	logic [7:0]                   prescale_d;
	logic [cwets_pkg::SEC_W-1:0]  sec_d;
	logic [cwets_pkg::MIN_W-1:0]  min_d;
	logic [cwets_pkg::HOUR_W-1:0] hour_d;
	logic                         colon_d;
	cwets_pkg::result_t           result_d;

	logic                         in_accept;
	logic                         cfg_write;

	// Tick path signals.
	logic [8:0]                   modulus;
	logic [8:0]                   pre_inc;
	logic                         sec_wrap;
	logic                         min_wrap;
	logic [cwets_pkg::SEC_W-1:0]  tick_sec;
	logic [cwets_pkg::MIN_W-1:0]  tick_min;
	logic [cwets_pkg::HOUR_W-1:0] tick_hour;

	// Sample path signals.
	logic                         enc_ha;
	logic                         enc_hb;
	logic                         enc_ma;
	logic                         enc_mb;
	logic                         mb_rise;
	logic                         mb_fall;
	logic signed [6:0]            hr_sum;
	logic signed [7:0]            mn_sum;
	logic [cwets_pkg::MIN_W-1:0]  smp_min;
	logic [cwets_pkg::HOUR_W-1:0] smp_hour;

	// Digit split.
	logic [2:0]                   min_tens;
	logic [3:0]                   min_ones;
	logic [2:0]                   hour_tens;
	logic [3:0]                   hour_ones;

	// Handshakes.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign pready        = 1'b1;
	assign cfg_write     = psel && penable && pwrite && pready
		&& (paddr[2] == cwets_pkg::REG_TICKS_PER_SECOND);

	// Register read back.
	always_comb begin
		prdata = '0;
		if (paddr[2] == cwets_pkg::REG_TICKS_PER_SECOND) begin
			prdata = {{(cwets_pkg::APB_DATA_W - cwets_pkg::TPS_W){1'b0}}, tps_q};
		end
	end

	// Timebase tick: prescaler, then the seconds, minutes and hours carry chain.
	always_comb begin
		modulus  = (tps_q == '0) ? 9'd256 : {1'b0, tps_q};
		pre_inc  = {1'b0, prescale_q} + 9'd1;
		sec_wrap = (sec_q == cwets_pkg::SEC_LAST);
		min_wrap = (min_q == cwets_pkg::MIN_LAST);
		tick_sec  = sec_wrap ? '0 : sec_q + 6'd1;
		tick_min  = min_q;
		tick_hour = hour_q;
		if (sec_wrap) begin
			tick_min = min_wrap ? '0 : min_q + 6'd1;
			if (min_wrap) begin
				tick_hour = (hour_q == cwets_pkg::HOUR_LAST) ? '0 : hour_q + 5'd1;
			end
		end
	end

	// Encoder sample: hour on a falling A edge, minute on quadrature steps.
	always_comb begin
		enc_ha  = s_axis_tdata[0];
		enc_hb  = s_axis_tdata[1];
		enc_ma  = s_axis_tdata[2];
		enc_mb  = s_axis_tdata[3];
		mb_rise = !last_mb_q && enc_mb;
		mb_fall = last_mb_q && !enc_mb;

		hr_sum = signed'({2'b00, hour_q});
		if (!enc_ha && last_ha_q) begin
			hr_sum = enc_hb ? hr_sum + 7'sd1 : hr_sum - 7'sd1;
		end

		mn_sum = signed'({2'b00, min_q});
		if (enc_ma == last_ma_q) begin
			if ((enc_ma && mb_rise) || (!enc_ma && mb_fall)) begin
				mn_sum = mn_sum + 8'sd1;
			end else if ((enc_ma && mb_fall) || (!enc_ma && mb_rise)) begin
				mn_sum = mn_sum - 8'sd1;
			end
		end

		// Minute wrap with carry or borrow into the hour.
		if (mn_sum >= 8'sd60) begin
			smp_min = '0;
			hr_sum  = hr_sum + 7'sd1;
		end else if (mn_sum < 8'sd0) begin
			smp_min = cwets_pkg::MIN_LAST;
			hr_sum  = hr_sum - 7'sd1;
		end else begin
			smp_min = mn_sum[cwets_pkg::MIN_W-1:0];
		end

		// Hour back into 0..23; the sum lies within -2..25.
		if (hr_sum < 7'sd0) begin
			hr_sum = hr_sum + 7'sd24;
		end else if (hr_sum >= 7'sd24) begin
			hr_sum = hr_sum - 7'sd24;
		end
		smp_hour = hr_sum[cwets_pkg::HOUR_W-1:0];
	end

	// Select the update for the request kind.
	always_comb begin
		prescale_d = prescale_q;
		sec_d      = sec_q;
		min_d      = min_q;
		hour_d     = hour_q;
		colon_d    = colon_q;
		case (s_axis_tuser[0])
			cwets_pkg::OP_TICK: begin
				if (pre_inc >= modulus) begin
					prescale_d = '0;
					sec_d      = tick_sec;
					min_d      = tick_min;
					hour_d     = tick_hour;
					colon_d    = !colon_q;
				end else begin
					prescale_d = pre_inc[7:0];
				end
			end
			cwets_pkg::OP_SAMPLE: begin
				min_d  = smp_min;
				hour_d = smp_hour;
			end
			default: begin
				prescale_d = prescale_q;
			end
		endcase
	end

	// Display patterns from the updated time.
	always_comb begin
		min_tens  = cwets_pkg::tens_of(min_d);
		min_ones  = cwets_pkg::ones_of(min_d, min_tens);
		hour_tens = cwets_pkg::tens_of({1'b0, hour_d});
		hour_ones = cwets_pkg::ones_of({1'b0, hour_d}, hour_tens);

		result_d.seconds_now     = sec_d;
		result_d.minutes_now     = min_d;
		result_d.hours_now       = hour_d;
		result_d.seg_minute_ones = cwets_pkg::digit_seg(min_ones);
		result_d.seg_minute_tens = cwets_pkg::digit_seg({1'b0, min_tens});
		result_d.seg_hour_ones   = cwets_pkg::digit_seg(hour_ones);
		result_d.seg_hour_tens   = (hour_tens == 3'd0) ? cwets_pkg::SEG_DARK
			: cwets_pkg::digit_seg({1'b0, hour_tens});
		result_d.seg_colon       = colon_d ? cwets_pkg::SEG_COLON_ON : cwets_pkg::SEG_DARK;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= cwets_pkg::TPS_RESET;
		end else if (cfg_write) begin
			tps_q <= pwdata[cwets_pkg::TPS_W-1:0];
		end
	end

	// Clock state, updated when a request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			sec_q      <= '0;
			min_q      <= '0;
			hour_q     <= '0;
			colon_q    <= 1'b1;
			last_ha_q  <= 1'b1;
			last_ma_q  <= 1'b0;
			last_mb_q  <= 1'b0;
		end else if (in_accept) begin
			prescale_q <= prescale_d;
			sec_q      <= sec_d;
			min_q      <= min_d;
			hour_q     <= hour_d;
			colon_q    <= colon_d;
			if (s_axis_tuser[0] == cwets_pkg::OP_SAMPLE) begin
				last_ha_q <= enc_ha;
				last_ma_q <= enc_ma;
				last_mb_q <= enc_mb;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(cwets_pkg::OUT_DATA_W - $bits(cwets_pkg::result_t)){1'b0}},
		result_q};

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench of the 24-hour clock with encoder time setting
// Drives tick and encoder-sample requests with random gaps on both streams,
// writes the prescaler modulus over APB between phases, and checks every
// result field by field against a clock model kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_top;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One line of the directed plan.
	typedef struct packed {
		row_kind_t           kind;
		logic                op;
		logic [3:0]          bits;
		logic [8:0]          reps;
		logic                pin;
		logic [7:0]          modulus;
		cwets_pkg::result_t  res;
	} plan_row_t;

	// Displays that can be read off directly; fields from colon down to seconds.
	localparam cwets_pkg::result_t MIDNIGHT =
		{8'hFC, 8'hFF, 8'hC0, 8'hC0, 8'hC0, 5'd0, 6'd0, 6'd0};
	localparam cwets_pkg::result_t AT_2300 =
		{8'hFC, 8'hA4, 8'hB0, 8'hC0, 8'hC0, 5'd23, 6'd0, 6'd0};
	localparam cwets_pkg::result_t AT_2359 =
		{8'hFC, 8'hA4, 8'hB0, 8'h92, 8'h98, 5'd23, 6'd59, 6'd0};

	localparam logic [cwets_pkg::APB_ADDR_W-1:0] TPS_ADDR =
		{cwets_pkg::REG_TICKS_PER_SECOND, 2'b00};
	localparam int PHASE_ITEMS = 90;

	// Active-low digit patterns for 0 through 9.
	localparam logic [7:0] SEG_LUT [0:9] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
		8'h92, 8'h82, 8'hF8, 8'h80, 8'h98};

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [cwets_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // [3:0] encoder_bits, [7:4] zero
	logic [0:0]                       s_axis_tuser = '0;   // [0] operation
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [cwets_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // seconds, minutes, hours, segments
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [cwets_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [cwets_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [cwets_pkg::APB_DATA_W-1:0] prdata;
	logic                             pready;

	clock_with_encoder_time_set u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Clock model state and its modulus register.
	logic [7:0] tps_r = cwets_pkg::TPS_RESET;
	int         div_cnt = 0;
	int         sec_cnt = 0;
	int         min_cnt = 0;
	int         hour_cnt = 0;
	logic       colon_on = 1'b1;
	logic       hour_a_prev = 1'b1;
	logic       min_a_prev = 1'b0;
	logic       min_b_prev = 1'b0;

	// Expected displays, oldest first, and bookkeeping.
	cwets_pkg::result_t display_q [$];
	logic               pin_on = 1'b0;
	cwets_pkg::result_t pin_res = '0;
	logic               steady = 1'b0;
	logic [3:0]         enc_drive = 4'b0001;
	int                 err_count = 0;
	int                 n_sent = 0;
	int                 n_checked = 0;
	int                 n_cfg = 0;
	plan_row_t          plan [0:31];
	int                 n_rows = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advance the clock model by one request and return the display it shows.
	function automatic cwets_pkg::result_t clock_step(input logic op, input logic [3:0] bits);
		int                 modulus;
		int                 hr;
		int                 mn;
		logic               rise;
		logic               fall;
		cwets_pkg::result_t r;
		if (op == cwets_pkg::OP_TICK) begin
			modulus = (tps_r == 8'd0) ? 256 : int'(tps_r);
			if (div_cnt + 1 >= modulus) begin
				div_cnt = 0;
				colon_on = ~colon_on;
				sec_cnt++;
				if (sec_cnt >= 60) begin
					sec_cnt = 0;
					min_cnt++;
					if (min_cnt >= 60) begin
						min_cnt = 0;
						hour_cnt = (hour_cnt + 1) % 24;
					end
				end
			end else begin
				div_cnt++;
			end
		end else begin
			hr = hour_cnt;
			mn = min_cnt;
			// Hour knob moves on a falling A line; B gives the direction.
			if (!bits[0] && hour_a_prev)
				hr = bits[1] ? hr + 1 : hr - 1;
			hour_a_prev = bits[0];
			// Minute knob counts B transitions while A holds still.
			if (bits[2] == min_a_prev) begin
				rise = !min_b_prev && bits[3];
				fall = min_b_prev && !bits[3];
				if (bits[2])
					mn = mn + (rise ? 1 : 0) - (fall ? 1 : 0);
				else
					mn = mn + (fall ? 1 : 0) - (rise ? 1 : 0);
			end
			min_a_prev = bits[2];
			min_b_prev = bits[3];
			if (mn >= 60) begin
				mn = 0;
				hr++;
			end else if (mn < 0) begin
				mn = 59;
				hr--;
			end
			hour_cnt = ((hr % 24) + 24) % 24;
			min_cnt = mn;
		end
		r.seconds_now     = sec_cnt[5:0];
		r.minutes_now     = min_cnt[5:0];
		r.hours_now       = hour_cnt[4:0];
		r.seg_minute_ones = SEG_LUT[min_cnt % 10];
		r.seg_minute_tens = SEG_LUT[min_cnt / 10];
		r.seg_hour_ones   = SEG_LUT[hour_cnt % 10];
		r.seg_hour_tens   = (hour_cnt < 10) ? cwets_pkg::SEG_DARK : SEG_LUT[hour_cnt / 10];
		r.seg_colon       = colon_on ? cwets_pkg::SEG_COLON_ON : cwets_pkg::SEG_DARK;
		return r;
	endfunction

	// Compare one result with its expectation, field by field.
	task automatic check_display(input cwets_pkg::result_t want,
			input logic [cwets_pkg::OUT_DATA_W-1:0] bus);
		cwets_pkg::result_t got;
		int                 wv [0:7];
		int                 gv [0:7];
		string              nm [0:7];
		got = bus[$bits(cwets_pkg::result_t)-1:0];
		wv[0] = want.seconds_now;     gv[0] = got.seconds_now;     nm[0] = "seconds_now";
		wv[1] = want.minutes_now;     gv[1] = got.minutes_now;     nm[1] = "minutes_now";
		wv[2] = want.hours_now;       gv[2] = got.hours_now;       nm[2] = "hours_now";
		wv[3] = want.seg_minute_ones; gv[3] = got.seg_minute_ones; nm[3] = "seg_minute_ones";
		wv[4] = want.seg_minute_tens; gv[4] = got.seg_minute_tens; nm[4] = "seg_minute_tens";
		wv[5] = want.seg_hour_ones;   gv[5] = got.seg_hour_ones;   nm[5] = "seg_hour_ones";
		wv[6] = want.seg_hour_tens;   gv[6] = got.seg_hour_tens;   nm[6] = "seg_hour_tens";
		wv[7] = want.seg_colon;       gv[7] = got.seg_colon;       nm[7] = "seg_colon";
		for (int i = 0; i < 8; i++) begin
			if (wv[i] !== gv[i]) begin
				$display("%0t: %s expected 0x%0h, got 0x%0h", $time, nm[i], wv[i], gv[i]);
				err_count++;
			end
		end
		if (bus[cwets_pkg::OUT_DATA_W-1:$bits(cwets_pkg::result_t)] !== '0) begin
			$display("%0t: tdata padding expected 0x0, got 0x%0h", $time,
				bus[cwets_pkg::OUT_DATA_W-1:$bits(cwets_pkg::result_t)]);
			err_count++;
		end
	endtask

	// Watch both streams and the APB port at every rising edge.
	always @(posedge clk) begin : watch
		cwets_pkg::result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = clock_step(s_axis_tuser[0], s_axis_tdata[3:0]);
				if (pin_on)
					want = pin_res;
				display_q.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				n_checked++;
				if (display_q.size() == 0) begin
					$display("%0t: result with nothing expected, got 0x%0h", $time, m_axis_tdata);
					err_count++;
				end else begin
					check_display(display_q.pop_front(), m_axis_tdata);
				end
			end
			if (psel && penable && pready) begin
				if (pwrite && paddr[2] == cwets_pkg::REG_TICKS_PER_SECOND)
					tps_r = pwdata[7:0];
				else if (!pwrite && prdata !== cwets_pkg::APB_DATA_W'(tps_r)) begin
					$display("%0t: ticks_per_second read expected 0x%0h, got 0x%0h",
						$time, tps_r, prdata);
					err_count++;
				end
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result sink with random back-pressure.
	initial begin : sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// Offer one request and hold it until it is taken.
	task automatic push_request(input logic op, input logic [3:0] bits, input int gap,
			input logic pin, input cwets_pkg::result_t res);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0000, bits};
		pin_on  = pin;
		pin_res = res;
		if (op == cwets_pkg::OP_SAMPLE)
			enc_drive = bits;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		n_sent++;
	endtask

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_xfer(input logic wr, input logic [cwets_pkg::APB_ADDR_W-1:0] addr,
			input logic [cwets_pkg::APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drain every outstanding result, then write and read back the modulus.
	task automatic set_modulus(input logic [7:0] value);
		s_axis_tvalid <= 1'b0;
		while (display_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		apb_xfer(1'b1, TPS_ADDR, cwets_pkg::APB_DATA_W'(value));
		apb_xfer(1'b0, TPS_ADDR, '0);
		n_cfg++;
	endtask

	// Next encoder sample: mostly one clean knob step, sometimes noise.
	function automatic logic [3:0] next_encoder_bits();
		logic [3:0] b;
		int         r;
		if ($urandom_range(0, 99) < 15)
			return 4'($urandom_range(0, 15));
		b = enc_drive;
		r = $urandom_range(0, 99);
		if (r < 30)
			b[0] = ~b[0];
		else if (r < 45)
			b[1] = ~b[1];
		r = $urandom_range(0, 99);
		if (r < 40)
			b[2] = ~b[2];
		else if (r < 80)
			b[3] = ~b[3];
		return b;
	endfunction

	task automatic add_item(input logic op, input logic [3:0] bits, input int reps,
			input logic pin, input cwets_pkg::result_t res);
		plan[n_rows] = {ROW_ITEM, op, bits, 9'(reps), pin, 8'd0, res};
		n_rows++;
	endtask

	task automatic add_cfg(input logic [7:0] value);
		plan[n_rows] = {ROW_CFG, cwets_pkg::OP_TICK, 4'd0, 9'd1, 1'b0, value, MIDNIGHT};
		n_rows++;
	endtask

	// Main sequence: reset, directed plan, random phases, drain, verdict.
	initial begin : main
		logic [7:0] tps_list [0:7];
		logic       op;
		logic [3:0] bits;
		int         k;

		// Reset view, then both hour knob directions and a minute step down, with wrap.
		add_item(cwets_pkg::OP_SAMPLE, 4'b0001, 1, 1'b1, MIDNIGHT);
		add_item(cwets_pkg::OP_TICK,   4'b1111, 1, 1'b1, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b0000, 1, 1'b1, AT_2300);
		add_item(cwets_pkg::OP_SAMPLE, 4'b0001, 1, 1'b0, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b0010, 1, 1'b1, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b1001, 1, 1'b1, AT_2359);
		// One tick per second from 23:59:00 rolls the whole day over.
		add_cfg(8'd1);
		add_item(cwets_pkg::OP_TICK,   4'b0000, 60, 1'b1, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b0001, 1, 1'b0, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b0101, 1, 1'b0, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b1101, 1, 1'b0, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b0101, 1, 1'b0, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b1100, 1, 1'b0, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b1111, 1, 1'b0, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b0110, 1, 1'b0, MIDNIGHT);
		add_item(cwets_pkg::OP_SAMPLE, 4'b1010, 1, 1'b0, MIDNIGHT);
		// A zero modulus counts 256 ticks per second.
		add_cfg(8'd0);
		add_item(cwets_pkg::OP_TICK,   4'b0000, 256, 1'b0, MIDNIGHT);
		// Lowering the modulus below the running count.
		add_cfg(8'd255);
		add_item(cwets_pkg::OP_TICK,   4'b1010, 200, 1'b0, MIDNIGHT);
		add_cfg(8'd5);
		add_item(cwets_pkg::OP_TICK,   4'b0101, 4, 1'b0, MIDNIGHT);

		tps_list = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd7, 8'd60, 8'd3, 8'd1};
		tps_list[5] = 8'($urandom_range(1, 255));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed plan.
		for (int i = 0; i < n_rows; i++) begin
			if (plan[i].kind == ROW_CFG) begin
				set_modulus(plan[i].modulus);
			end else begin
				for (k = 0; k < int'(plan[i].reps); k++)
					push_request(plan[i].op, plan[i].bits, pick_gap(),
						plan[i].pin && k == int'(plan[i].reps) - 1, plan[i].res);
			end
		end

		// Random phases, one modulus setting each; two of them run without gaps.
		for (int ph = 0; ph < 8; ph++) begin
			set_modulus(tps_list[ph]);
			steady = (ph == 3 || ph == 6);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				op = ($urandom_range(0, 99) < 55) ? cwets_pkg::OP_TICK : cwets_pkg::OP_SAMPLE;
				bits = (op == cwets_pkg::OP_TICK) ? 4'($urandom_range(0, 15))
					: next_encoder_bits();
				push_request(op, bits, pick_gap(), 1'b0, MIDNIGHT);
			end
			steady = 1'b0;
		end

		s_axis_tvalid <= 1'b0;
		while (display_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d tick and encoder requests under %0d modulus settings,", n_sent, n_cfg);
		$display("and compared %0d results with the clock model.", n_checked);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Hard stop if the run hangs.
	initial begin
		#10_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
